/* rtl/track_fifos_into_bounded_stack_defines.svh */
// assertion macros shared by the packing machine rtl
`ifndef TRACK_FIFOS_INTO_BOUNDED_STACK_DEFINES_SVH
`define TRACK_FIFOS_INTO_BOUNDED_STACK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TFBS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TFBS_ASSERT_SAME(lbl, ante, cons, msg)
`define TFBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/tfbs_pkg.sv */
// shared types and constants for the packing machine
`timescale 1ns / 1ps
package tfbs_pkg;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [3:0] BTN_BASKET = 4'd0;

    localparam logic CFG_BASKET_CAPACITY = 1'b0;
    localparam logic CFG_ACTIVE_TRACKS   = 1'b1;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;
    localparam logic [3:0] TRACKS_RESET   = 4'd8;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_PUSH,
        CMD_POP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_back_state;

endpackage

/* rtl/track_fifos_into_bounded_stack.sv */
// top level of the packing machine: track fifos feeding a bounded basket
//
// items enter on the s_axis channel: tuser carries the opcode (load or press),
// tdata carries the button and a byte. a load appends the byte to track
// button-1; a press of button 0 pops the basket top, a press of button k moves
// the head of track k-1 onto the basket, forcing the top out first when the
// basket is at capacity. popped bytes leave on the m_axis channel, one per item
// at most. the cfg port writes basket capacity and the number of active tracks.
// the front stage classifies an item in the cycle it is accepted and queues a
// command unless the item is ignored; the back stage writes a load straight into
// the track memory. for a push or pop the back stage reads the track and basket
// memories in its idle state, then writes the basket and loads the output register
// in its exec state; it takes no new command while in exec. a stalled receiver
// holds the output register; the back stage waits, the two-entry queue fills and
// then s_axis_tready drops.
// reset empties all tracks and the basket and restores capacity 64 and 8 tracks.
`timescale 1ns / 1ps
module track_fifos_into_bounded_stack #(
    parameter int NUM_TRACKS   = 8,
    parameter int TRACK_DEPTH  = 128,
    parameter int BASKET_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // button[3:0], item_value[11:4], zero pad
    input  logic        i_s_axis_tuser,  // opcode[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // conveyor_item[7:0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    localparam int TRACK_WORDS = NUM_TRACKS * TRACK_DEPTH;
    localparam int AW = (TRACK_WORDS > 1) ? $clog2(TRACK_WORDS) : 1;

    logic [6:0] r_capacity;
    logic [3:0] r_tracks;

    logic           f_cmd_valid;
    logic           f_cmd_ready;
    tfbs_pkg::t_cmd f_cmd;
    logic [AW-1:0]  f_cmd_addr;
    logic           q_valid;
    logic           q_ready;
    tfbs_pkg::t_cmd q_cmd;
    logic [AW-1:0]  q_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= tfbs_pkg::CAPACITY_RESET;
            r_tracks   <= tfbs_pkg::TRACKS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tfbs_pkg::CFG_BASKET_CAPACITY: r_capacity <= i_cfg_wdata;
                tfbs_pkg::CFG_ACTIVE_TRACKS:   r_tracks   <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    tfbs_front #(
        .NUM_TRACKS  (NUM_TRACKS),
        .TRACK_DEPTH (TRACK_DEPTH),
        .AW          (AW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_opcode        (i_s_axis_tuser),
        .i_button        (i_s_axis_tdata[3:0]),
        .i_item          (i_s_axis_tdata[11:4]),
        .i_active_tracks (r_tracks),
        .o_cmd_valid     (f_cmd_valid),
        .i_cmd_ready     (f_cmd_ready),
        .o_cmd           (f_cmd),
        .o_cmd_addr      (f_cmd_addr)
    );

    tfbs_queue #(
        .AW (AW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_cmd_valid),
        .o_ready (f_cmd_ready),
        .i_cmd   (f_cmd),
        .i_addr  (f_cmd_addr),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr)
    );

    tfbs_back #(
        .NUM_TRACKS   (NUM_TRACKS),
        .TRACK_DEPTH  (TRACK_DEPTH),
        .BASKET_DEPTH (BASKET_DEPTH),
        .AW           (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .i_cmd_addr  (q_addr),
        .i_capacity  (r_capacity),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_item      (o_m_axis_tdata)
    );

endmodule

/* rtl/tfbs_front.sv */
// front end: accepts items, tracks fifo heads and fills, issues commands
`timescale 1ns / 1ps
module tfbs_front #(
    parameter int NUM_TRACKS  = 8,
    parameter int TRACK_DEPTH = 128,
    parameter int AW          = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_opcode,
    input  logic [3:0]        i_button,
    input  logic [7:0]        i_item,
    input  logic [3:0]        i_active_tracks,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output tfbs_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_cmd_addr
);

    localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int HW = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int FW = $clog2(TRACK_DEPTH + 1);
    localparam int SW = FW + 1;

    logic [HW-1:0] r_head [NUM_TRACKS];
    logic [FW-1:0] r_fill [NUM_TRACKS];

    logic [3:0]    eff_tracks;
    logic [3:0]    trk;
    logic          in_range;
    logic [TW-1:0] idx;
    logic [HW-1:0] head;
    logic [FW-1:0] fill;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_off;
    logic [AW-1:0] base;
    logic          is_cmd;
    logic          accept;

    always_comb begin
        eff_tracks = (i_active_tracks > 4'(NUM_TRACKS)) ? 4'(NUM_TRACKS) : i_active_tracks;
        trk        = i_button - 4'd1;
        in_range   = (i_button != tfbs_pkg::BTN_BASKET) && (trk < eff_tracks);
        idx        = trk[TW-1:0];
        head       = in_range ? r_head[idx] : '0;
        fill       = in_range ? r_fill[idx] : '0;
        tail_sum   = SW'(head) + SW'(fill);
        tail_off   = (tail_sum >= SW'(TRACK_DEPTH)) ? tail_sum - SW'(TRACK_DEPTH) : tail_sum;
        base       = AW'(idx) * AW'(TRACK_DEPTH);
        is_cmd     = 1'b0;
        o_cmd.kind = tfbs_pkg::CMD_POP;
        o_cmd.data = i_item;
        o_cmd_addr = base + AW'(head);
        if (i_opcode == tfbs_pkg::OP_LOAD) begin
            o_cmd.kind = tfbs_pkg::CMD_LOAD;
            o_cmd_addr = base + AW'(tail_off);
            is_cmd     = in_range && (SW'(fill) < SW'(TRACK_DEPTH));
        end else if (i_button == tfbs_pkg::BTN_BASKET) begin
            is_cmd = 1'b1;
        end else begin
            o_cmd.kind = tfbs_pkg::CMD_PUSH;
            is_cmd     = in_range && (fill != '0);
        end
        o_ready     = i_cmd_ready;
        o_cmd_valid = i_valid && is_cmd;
        accept      = i_valid && i_cmd_ready && is_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TRACKS; i++) begin
                r_head[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (accept) begin
            if (o_cmd.kind == tfbs_pkg::CMD_LOAD) begin
                r_fill[idx] <= fill + FW'(1);
            end else if (o_cmd.kind == tfbs_pkg::CMD_PUSH) begin
                r_head[idx] <= (head == HW'(TRACK_DEPTH - 1)) ? '0 : head + HW'(1);
                r_fill[idx] <= fill - FW'(1);
            end
        end
    end

endmodule

/* rtl/tfbs_queue.sv */
// short command queue between front and back
`timescale 1ns / 1ps
`include "track_fifos_into_bounded_stack_defines.svh"
module tfbs_queue #(
    parameter int AW = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tfbs_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_addr,
    output logic           o_valid,
    input  logic           i_ready,
    output tfbs_pkg::t_cmd o_cmd,
    output logic [AW-1:0]  o_addr
);

    localparam int DEPTH = tfbs_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    tfbs_pkg::t_cmd r_cmd  [DEPTH];
    logic [AW-1:0]  r_addr [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           push;
    logic           pop;

    assign o_ready = (r_count < CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_cmd[r_rptr];
    assign o_addr  = r_addr[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wptr]  <= i_cmd;
            r_addr[r_wptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `TFBS_ASSERT_NEXT(a_q_count_up, push && !pop, r_count == $past(r_count) + CW'(1), "queue count lost a push")

endmodule

/* rtl/tfbs_back.sv */
// back end: track store, basket stack and conveyor output register
`timescale 1ns / 1ps
`include "track_fifos_into_bounded_stack_defines.svh"
module tfbs_back #(
    parameter int NUM_TRACKS   = 8,
    parameter int TRACK_DEPTH  = 128,
    parameter int BASKET_DEPTH = 64,
    parameter int AW           = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  tfbs_pkg::t_cmd i_cmd,
    input  logic [AW-1:0]  i_cmd_addr,
    input  logic [6:0]     i_capacity,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_item
);

    localparam int TRACK_WORDS = NUM_TRACKS * TRACK_DEPTH;
    localparam int BW   = (BASKET_DEPTH > 1) ? $clog2(BASKET_DEPTH) : 1;
    localparam int FLW  = $clog2(BASKET_DEPTH + 1);
    localparam int CMPW = (FLW > 7) ? FLW : 7;

    logic [7:0] r_track_mem  [TRACK_WORDS];
    logic [7:0] r_basket_mem [BASKET_DEPTH];

    tfbs_pkg::t_back_state r_state, n_state;
    logic [FLW-1:0] r_fill, n_fill;
    logic [BW-1:0]  r_wr_idx, n_wr_idx;
    logic           r_pend_wr, n_pend_wr;
    logic           r_pend_out, n_pend_out;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_item;
    logic [7:0]     r_track_rdata;
    logic [7:0]     r_basket_rdata;

    logic            take;
    logic            trk_we;
    logic            trk_re;
    logic            bsk_re;
    logic [FLW-1:0]  fill_m1;
    logic [BW-1:0]   top_idx;
    logic [CMPW-1:0] cap_eff;
    logic            forced;

    always_comb begin
        cap_eff = CMPW'(i_capacity);
        if (cap_eff == '0) begin
            cap_eff = CMPW'(1);
        end
        if (cap_eff > CMPW'(BASKET_DEPTH)) begin
            cap_eff = CMPW'(BASKET_DEPTH);
        end
        fill_m1 = r_fill - FLW'(1);
        top_idx = fill_m1[BW-1:0];
        forced  = (CMPW'(r_fill) >= cap_eff) && (r_fill != '0);
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_wr_idx    = r_wr_idx;
        n_pend_wr   = r_pend_wr;
        n_pend_out  = r_pend_out;
        n_out_valid = r_out_valid && !i_ready;
        take        = 1'b0;
        trk_we      = 1'b0;
        trk_re      = 1'b0;
        bsk_re      = 1'b0;
        unique case (r_state)
            tfbs_pkg::BK_IDLE: begin
                take = i_cmd_valid && (!r_out_valid || i_ready);
                if (take) begin
                    unique case (i_cmd.kind)
                        tfbs_pkg::CMD_LOAD: begin
                            trk_we = 1'b1;
                        end
                        tfbs_pkg::CMD_POP: begin
                            if (r_fill != '0) begin
                                bsk_re     = 1'b1;
                                n_fill     = fill_m1;
                                n_pend_wr  = 1'b0;
                                n_pend_out = 1'b1;
                                n_state    = tfbs_pkg::BK_EXEC;
                            end
                        end
                        tfbs_pkg::CMD_PUSH: begin
                            trk_re     = 1'b1;
                            n_pend_wr  = 1'b1;
                            n_pend_out = forced;
                            n_state    = tfbs_pkg::BK_EXEC;
                            if (forced) begin
                                bsk_re   = 1'b1;
                                n_wr_idx = top_idx;
                            end else begin
                                n_wr_idx = r_fill[BW-1:0];
                                n_fill   = r_fill + FLW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tfbs_pkg::BK_EXEC: begin
                if (r_pend_out) begin
                    n_out_valid = 1'b1;
                end
                n_state = tfbs_pkg::BK_IDLE;
            end
            default: begin
                n_state = tfbs_pkg::BK_IDLE;
            end
        endcase
        o_cmd_ready = take;
    end

    always_ff @(posedge i_clk) begin
        if (trk_we) begin
            r_track_mem[i_cmd_addr] <= i_cmd.data;
        end
        if (trk_re) begin
            r_track_rdata <= r_track_mem[i_cmd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tfbs_pkg::BK_EXEC && r_pend_wr) begin
            r_basket_mem[r_wr_idx] <= r_track_rdata;
        end
        if (bsk_re) begin
            r_basket_rdata <= r_basket_mem[top_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == tfbs_pkg::BK_EXEC && r_pend_out) begin
            r_out_item <= r_basket_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfbs_pkg::BK_IDLE;
            r_fill      <= '0;
            r_wr_idx    <= '0;
            r_pend_wr   <= 1'b0;
            r_pend_out  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_wr_idx    <= n_wr_idx;
            r_pend_wr   <= n_pend_wr;
            r_pend_out  <= n_pend_out;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `TFBS_ASSERT_NEXT(a_exec_one_cycle, r_state == tfbs_pkg::BK_EXEC, r_state == tfbs_pkg::BK_IDLE, "exec phase held too long")
    `TFBS_ASSERT_SAME(a_out_from_exec, $rose(r_out_valid), $past(r_state == tfbs_pkg::BK_EXEC), "output raised outside exec")
    `TFBS_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= FLW'(BASKET_DEPTH), "basket fill beyond depth")

endmodule

/* verif/track_fifos_into_bounded_stack_test.sv */
// self-checking stream testbench for the packing machine track fifos and basket
`timescale 1ns / 1ps
module track_fifos_into_bounded_stack_test;

    localparam int TRACKS       = 8;
    localparam int TRACK_DEPTH  = 128;
    localparam int BASKET_DEPTH = 64;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 2000;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_GIVES,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic       op;
        logic [3:0] btn;
        logic [7:0] val;
        logic [7:0] gives;
        logic       reg_idx;
        logic [6:0] reg_val;
    } t_row;

    typedef struct {
        int capacity;
        int tracks;
        int items;
        int load_pct;
        int pop_pct;
        bit idle;
        bit hold;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_addr;
    logic [6:0]  i_cfg_wdata;

    // basket top sits at the front of basket_q
    logic [7:0] track_q [TRACKS][$];
    logic [7:0] basket_q[$];
    logic [6:0] capacity_reg;
    logic [3:0] tracks_reg;
    logic [7:0] conveyor_expect[$];

    int errors;
    int idle_cycles;
    bit idle_on;
    bit hold_request;

    track_fifos_into_bounded_stack dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int eff_tracks();
        return (tracks_reg > TRACKS) ? TRACKS : int'(tracks_reg);
    endfunction

    function automatic int eff_capacity();
        if (capacity_reg == 0) return 1;
        return (capacity_reg > BASKET_DEPTH) ? BASKET_DEPTH : int'(capacity_reg);
    endfunction

    // one item through the track fifos and the basket
    task automatic predict_conveyor(input logic op, input logic [3:0] btn,
                                    input logic [7:0] val, output bit made,
                                    output logic [7:0] item);
        int t;
        made = 1'b0;
        item = '0;
        t = int'(btn) - 1;
        if (op == tfbs_pkg::OP_LOAD) begin
            if (btn != tfbs_pkg::BTN_BASKET && t < eff_tracks()
                && track_q[t].size() < TRACK_DEPTH)
                track_q[t] = {track_q[t], val};
        end else if (btn == tfbs_pkg::BTN_BASKET) begin
            if (basket_q.size() > 0) begin
                item = basket_q.pop_front();
                made = 1'b1;
            end
        end else if (t < eff_tracks() && track_q[t].size() > 0) begin
            if (basket_q.size() >= eff_capacity()) begin
                item = basket_q.pop_front();
                made = 1'b1;
            end
            basket_q.push_front(track_q[t].pop_front());
        end
    endtask

    function automatic t_row row_load(input logic [3:0] btn, input logic [7:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_PREDICT;
        r.op = tfbs_pkg::OP_LOAD;
        r.btn = btn;
        r.val = val;
        return r;
    endfunction

    function automatic t_row row_quiet(input logic [3:0] btn);
        t_row r;
        r = '0;
        r.kind = ROW_QUIET;
        r.op = tfbs_pkg::OP_PRESS;
        r.btn = btn;
        r.val = 8'h00;
        return r;
    endfunction

    function automatic t_row row_gives(input logic [3:0] btn, input logic [7:0] item);
        t_row r;
        r = '0;
        r.kind = ROW_GIVES;
        r.op = tfbs_pkg::OP_PRESS;
        r.btn = btn;
        r.val = 8'hFF;
        r.gives = item;
        return r;
    endfunction

    function automatic t_row row_write(input logic idx, input logic [6:0] val);
        t_row r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row random_row(input int load_pct, input int pop_pct);
        t_row r;
        int pick;
        int eff;
        r = '0;
        r.kind = ROW_PREDICT;
        r.val = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        eff = eff_tracks();
        if (pick < 5 || eff == 0) begin
            r.op = 1'($urandom_range(0, 1));
            r.btn = 4'($urandom_range(0, 15));
        end else if (pick < 5 + load_pct) begin
            r.op = tfbs_pkg::OP_LOAD;
            r.btn = 4'($urandom_range(1, eff));
        end else if (pick < 5 + load_pct + pop_pct) begin
            r.op = tfbs_pkg::OP_PRESS;
            r.btn = tfbs_pkg::BTN_BASKET;
        end else begin
            r.op = tfbs_pkg::OP_PRESS;
            r.btn = 4'($urandom_range(1, eff));
        end
        return r;
    endfunction

    task automatic send_item(input t_row r);
        int gap;
        bit made;
        logic [7:0] item;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata = {4'b0, r.val, r.btn};
        i_s_axis_tuser = r.op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_conveyor(r.op, r.btn, r.val, made, item);
        if (r.kind == ROW_GIVES) begin
            made = 1'b1;
            item = r.gives;
        end else if (r.kind == ROW_QUIET) begin
            made = 1'b0;
        end
        if (made) conveyor_expect = {conveyor_expect, item};
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (conveyor_expect.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] val);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == tfbs_pkg::CFG_BASKET_CAPACITY) capacity_reg = val;
        else tracks_reg = val[3:0];
    endtask

    // receiver: random stalls per item while idle_on is set, plus one long hold-off on request
    initial begin
        int w;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_m_axis_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            w = idle_on ? $urandom_range(0, 8) : 0;
            if (w > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (w) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid && !hold_request);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin : conveyor_check
        logic [7:0] want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (conveyor_expect.size() == 0) begin
                $display("%0t: unexpected conveyor item, expected none, actual %02h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                want = conveyor_expect.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $display("%0t: conveyor item mismatch, expected %02h, actual %02h",
                             $time, want, o_m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row plan[$];
        t_phase phases[$];
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = 1'b0;
        i_cfg_wdata = '0;
        errors = 0;
        idle_cycles = 0;
        idle_on = 1'b1;
        hold_request = 1'b0;
        capacity_reg = tfbs_pkg::CAPACITY_RESET;
        tracks_reg = tfbs_pkg::TRACKS_RESET;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        plan = '{
            row_quiet(tfbs_pkg::BTN_BASKET),
            row_quiet(4'd1),
            row_load(tfbs_pkg::BTN_BASKET, 8'hAA),
            row_load(4'd9, 8'h11),
            row_load(4'd15, 8'hFF),
            row_load(4'd1, 8'h00),
            row_load(4'd1, 8'hFF),
            row_load(4'd8, 8'h5A),
            row_quiet(4'd1),
            row_quiet(4'd1),
            row_gives(tfbs_pkg::BTN_BASKET, 8'hFF),
            row_quiet(4'd8),
            row_gives(tfbs_pkg::BTN_BASKET, 8'h5A),
            row_gives(tfbs_pkg::BTN_BASKET, 8'h00),
            row_quiet(tfbs_pkg::BTN_BASKET),
            row_quiet(4'd9),
            row_quiet(4'd15),
            row_write(tfbs_pkg::CFG_BASKET_CAPACITY, 7'd1),
            row_load(4'd2, 8'hA5),
            row_load(4'd2, 8'h3C),
            row_quiet(4'd2),
            row_gives(4'd2, 8'hA5),
            // capacity zero acts as one
            row_write(tfbs_pkg::CFG_BASKET_CAPACITY, 7'd0),
            row_load(4'd3, 8'h11),
            row_gives(4'd3, 8'h3C),
            row_gives(tfbs_pkg::BTN_BASKET, 8'h11),
            row_write(tfbs_pkg::CFG_ACTIVE_TRACKS, 7'd0),
            row_load(4'd1, 8'h77),
            row_quiet(4'd1),
            row_write(tfbs_pkg::CFG_BASKET_CAPACITY, tfbs_pkg::CAPACITY_RESET),
            row_write(tfbs_pkg::CFG_ACTIVE_TRACKS, {3'b0, tfbs_pkg::TRACKS_RESET})
        };
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) write_reg(plan[i].reg_idx, plan[i].reg_val);
            else send_item(plan[i]);
        end

        phases = '{
            '{64, 8, 200, 45, 10, 1'b1, 1'b1},
            '{1, 8, 150, 45, 10, 1'b1, 1'b0},
            '{127, 15, 300, 50, 2, 1'b1, 1'b0},
            '{0, 3, 150, 45, 10, 1'b0, 1'b0},
            '{5, 1, 200, 90, 3, 1'b1, 1'b0},
            '{64, 0, 40, 0, 0, 1'b1, 1'b0},
            '{33, 8, 200, 45, 15, 1'b1, 1'b0},
            '{2, 15, 150, 40, 20, 1'b0, 1'b0}
        };
        foreach (phases[p]) begin
            write_reg(tfbs_pkg::CFG_BASKET_CAPACITY, 7'(phases[p].capacity));
            write_reg(tfbs_pkg::CFG_ACTIVE_TRACKS, 7'(phases[p].tracks));
            idle_on = phases[p].idle;
            if (phases[p].hold) hold_request = 1'b1;
            for (int n = 0; n < phases[p].items; n++)
                send_item(random_row(phases[p].load_pct, phases[p].pop_pct));
        end

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
